// ----- rtl/core/tile_sprite_pixel_renderer_assert.svh -----
// Assertion macros for the pixel renderer.
`ifndef TILE_SPRITE_PIXEL_RENDERER_ASSERT_SVH
`define TILE_SPRITE_PIXEL_RENDERER_ASSERT_SVH
`define TSPR_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m");
`define TSPR_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m");
`endif

// ----- rtl/core/tspr_pkg.sv -----
package tspr_pkg;
  typedef enum logic [1:0] {
    ACT_VRAM  = 2'd0,
    ACT_OAM   = 2'd1,
    ACT_DRAW  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MAP, ST_TLO, ST_THI, ST_SCAN, ST_SLO, ST_SHI, ST_SPHI, ST_DONE,
    ST_OUT
  } state_t;

  localparam logic [2:0] REG_MAP_SEL = 3'd0;
  localparam logic [2:0] REG_TILE_UNS = 3'd1;
  localparam logic [2:0] REG_SCY = 3'd2;
  localparam logic [2:0] REG_SCX = 3'd3;
  localparam logic [2:0] REG_BGP = 3'd4;
  localparam logic [2:0] REG_OBP0 = 3'd5;
  localparam logic [2:0] REG_OBP1 = 3'd6;

  localparam int SPRITE_BYTES = 160;
  localparam int TABLE_SPRITES = 40;

  // Read address selection for the shared video memory port.
  typedef enum logic [1:0] {
    RA_MAP, RA_BG_LO, RA_BG_HI, RA_SP
  } rsel_t;

  typedef struct packed {
    logic   load;       // capture the render request
    logic   vram_wr;
    logic   oam_wr;
    logic   clr_wr;
    rsel_t  rsel;
    logic   sp_hi;      // sprite high byte address
    logic   cap_tile;
    logic   cap_lo;
    logic   cap_bg;
    logic   scan_start;
    logic   scan_step;
    logic   scan_chk;   // check the fetched sprite entry
    logic   cap_slo;
    logic   finish;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_hit;
    logic scan_end;
  } stat_t;

  function automatic logic [1:0] pal_map(input logic [7:0] pal, input logic [1:0] idx);
    pal_map = pal[{idx, 1'b0} +: 2];
  endfunction
endpackage

// ----- rtl/core/tspr_if.sv -----
interface tspr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [12:0] mem_address;
  logic [7:0] mem_data;
  logic [7:0] screen_line;
  logic [7:0] screen_column;
  modport source (output valid, action, mem_address, mem_data, screen_line, screen_column,
                  input ready);
  modport sink (input valid, action, mem_address, mem_data, screen_line, screen_column,
                output ready);
endinterface

interface tspr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_line;
  logic [7:0] out_column;
  logic [1:0] shade;
  logic       from_sprite;
  modport source (output valid, out_line, out_column, shade, from_sprite, input ready);
  modport sink (input valid, out_line, out_column, shade, from_sprite, output ready);
endinterface

// ----- rtl/core/tile_sprite_pixel_renderer.sv -----
// Write items are taken in the idle state. A render item passes the map read, the two
// tile byte reads, the sprite table scan (SPRITE_COUNT capped at 40) and the two sprite
// byte reads, then is offered until the output takes it. One video memory port serves
// map, two tile bytes and two sprite bytes, and the sprite table is scanned one entry per
// cycle until the first covering sprite or its last entry. One item is in flight at a time.
// Synchronous active-high reset clears state and configuration registers, then a clearing
// pass zeroes both memories before the first item is accepted.
`include "tile_sprite_pixel_renderer_assert.svh"
module tile_sprite_pixel_renderer #(
  parameter int SPRITE_COUNT = 40,
  parameter int SCREEN_WIDTH = 160,
  parameter int SCREEN_LINES = 144,
  parameter int VIDEO_BYTES = 8192
) (
  input  logic        clk,
  input  logic        rst,
  tspr_in_if.sink     in_ch,
  tspr_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic map_sel, tile_uns;
  logic [7:0] scy, scx, bgp, obp0, obp1;
  tspr_pkg::cmd_t cmd;
  tspr_pkg::stat_t stat;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      map_sel <= 1'b0;
      tile_uns <= 1'b1;
      scy <= 8'd0;
      scx <= 8'd0;
      bgp <= 8'd252;
      obp0 <= 8'd255;
      obp1 <= 8'd255;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      unique case (ridx)
        tspr_pkg::REG_MAP_SEL:  map_sel <= pwdata[0];
        tspr_pkg::REG_TILE_UNS: tile_uns <= pwdata[0];
        tspr_pkg::REG_SCY:      scy <= pwdata[7:0];
        tspr_pkg::REG_SCX:      scx <= pwdata[7:0];
        tspr_pkg::REG_BGP:      bgp <= pwdata[7:0];
        tspr_pkg::REG_OBP0:     obp0 <= pwdata[7:0];
        tspr_pkg::REG_OBP1:     obp1 <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      tspr_pkg::REG_MAP_SEL:  prdata = {31'd0, map_sel};
      tspr_pkg::REG_TILE_UNS: prdata = {31'd0, tile_uns};
      tspr_pkg::REG_SCY:      prdata = {24'd0, scy};
      tspr_pkg::REG_SCX:      prdata = {24'd0, scx};
      tspr_pkg::REG_BGP:      prdata = {24'd0, bgp};
      tspr_pkg::REG_OBP0:     prdata = {24'd0, obp0};
      tspr_pkg::REG_OBP1:     prdata = {24'd0, obp1};
      default:                prdata = 32'd0;
    endcase
  end

  tspr_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_action(in_ch.action), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  tspr_datapath #(
    .SPRITE_COUNT(SPRITE_COUNT), .VIDEO_BYTES(VIDEO_BYTES)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_address(in_ch.mem_address), .in_data(in_ch.mem_data),
    .in_line(in_ch.screen_line), .in_column(in_ch.screen_column),
    .map_sel(map_sel), .tile_uns(tile_uns), .scy(scy), .scx(scx),
    .bgp(bgp), .obp0(obp0), .obp1(obp1),
    .out_line(out_ch.out_line), .out_column(out_ch.out_column),
    .shade(out_ch.shade), .from_sprite(out_ch.from_sprite)
  );

  `TSPR_ASSERT_IMPL(a_no_overlap, clk, rst, out_ch.valid, !in_ch.ready)
  `TSPR_ASSERT_NEXT(a_out_held, clk, rst, out_ch.valid && !out_ch.ready,
                    out_ch.valid && $stable(out_ch.shade) && $stable(out_ch.from_sprite))
endmodule

// ----- rtl/core/tspr_ctrl.sv -----
module tspr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_action,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tspr_pkg::stat_t   stat,
  output tspr_pkg::cmd_t    cmd
);
  tspr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= tspr_pkg::ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.rsel = tspr_pkg::RA_MAP;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      tspr_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_done) state_next = tspr_pkg::ST_IDLE;
      end
      tspr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == tspr_pkg::ACT_VRAM) cmd.vram_wr = 1'b1;
          if (in_action == tspr_pkg::ACT_OAM) cmd.oam_wr = 1'b1;
          if (in_action == tspr_pkg::ACT_DRAW) begin
            cmd.load = 1'b1;
            state_next = tspr_pkg::ST_MAP;
          end
        end
      end
      tspr_pkg::ST_MAP: begin
        cmd.rsel = tspr_pkg::RA_MAP;
        state_next = tspr_pkg::ST_TLO;
      end
      tspr_pkg::ST_TLO: begin
        cmd.cap_tile = 1'b1;
        state_next = tspr_pkg::ST_THI;
      end
      tspr_pkg::ST_THI: begin
        cmd.rsel = tspr_pkg::RA_BG_LO;
        cmd.scan_start = 1'b1;
        state_next = tspr_pkg::ST_SCAN;
      end
      tspr_pkg::ST_SCAN: begin
        // Tile low byte was read last cycle; high byte read now.
        // The first sprite entry is fetched from the table in this cycle.
        cmd.rsel = tspr_pkg::RA_BG_HI;
        cmd.cap_lo = 1'b1;
        cmd.scan_step = 1'b1;
        state_next = tspr_pkg::ST_SLO;
      end
      tspr_pkg::ST_SLO: begin
        cmd.cap_bg = 1'b1;
        cmd.scan_chk = 1'b1;
        cmd.scan_step = !stat.scan_hit;
        cmd.rsel = tspr_pkg::RA_SP;
        if (stat.scan_hit || stat.scan_end) state_next = tspr_pkg::ST_SHI;
        else state_next = tspr_pkg::ST_DONE;
      end
      tspr_pkg::ST_DONE: begin
        // Walk the sprite table one entry a cycle.
        cmd.scan_chk = 1'b1;
        cmd.scan_step = !stat.scan_hit;
        cmd.rsel = tspr_pkg::RA_SP;
        if (stat.scan_hit || stat.scan_end) state_next = tspr_pkg::ST_SHI;
      end
      tspr_pkg::ST_SHI: begin
        // The winning sprite's tile and row are registered now; read its low byte.
        cmd.rsel = tspr_pkg::RA_SP;
        state_next = tspr_pkg::ST_SPHI;
      end
      tspr_pkg::ST_SPHI: begin
        cmd.rsel = tspr_pkg::RA_SP;
        cmd.sp_hi = 1'b1;
        cmd.cap_slo = 1'b1;
        state_next = tspr_pkg::ST_OUT;
      end
      tspr_pkg::ST_OUT: begin
        out_valid = 1'b1;
        cmd.finish = 1'b1;
        if (out_ready) state_next = tspr_pkg::ST_IDLE;
      end
      default: state_next = tspr_pkg::ST_IDLE;
    endcase
  end
endmodule

// ----- rtl/core/tspr_datapath.sv -----
module tspr_datapath #(
  parameter int SPRITE_COUNT = 40,
  parameter int VIDEO_BYTES = 8192
) (
  input  logic            clk,
  input  logic            rst,
  input  tspr_pkg::cmd_t  cmd,
  output tspr_pkg::stat_t stat,
  input  logic [12:0]     in_address,
  input  logic [7:0]      in_data,
  input  logic [7:0]      in_line,
  input  logic [7:0]      in_column,
  input  logic            map_sel,
  input  logic            tile_uns,
  input  logic [7:0]      scy,
  input  logic [7:0]      scx,
  input  logic [7:0]      bgp,
  input  logic [7:0]      obp0,
  input  logic [7:0]      obp1,
  output logic [7:0]      out_line,
  output logic [7:0]      out_column,
  output logic [1:0]      shade,
  output logic            from_sprite
);
  localparam int AW = $clog2(VIDEO_BYTES);
  localparam int NS = (SPRITE_COUNT < tspr_pkg::TABLE_SPRITES) ? SPRITE_COUNT
                    : tspr_pkg::TABLE_SPRITES;
  localparam int SW = $clog2(tspr_pkg::TABLE_SPRITES + 1);

  logic [7:0] vram [VIDEO_BYTES];
  // One word per sprite: y in bits 7:0, x in 15:8, tile in 23:16, attributes in 31:24.
  logic [31:0] oam [tspr_pkg::TABLE_SPRITES];
  logic [31:0] oam_q;
  logic [7:0] rdata;
  logic [AW-1:0] raddr, clr_addr;
  logic [7:0] line, col, by, bx, tile, bg_lo, sp_lo, sp_tile, sp_attr;
  logic [1:0] bg_idx;
  logic [SW-1:0] scan, scan_q;
  logic [2:0] sp_row, sp_col;
  logic hit, found;
  logic [12:0] bg_tile_addr;

  // Clearing pass over video memory; sprite table cleared alongside.
  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clr_wr) clr_addr <= clr_addr + 1'b1;
  end
  assign stat.clr_done = &clr_addr;

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) vram[clr_addr] <= 8'd0;
    else if (cmd.vram_wr) vram[in_address[AW-1:0]] <= in_data;
    rdata <= vram[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr && clr_addr < AW'(tspr_pkg::TABLE_SPRITES))
      oam[clr_addr[SW-1:0]] <= '0;
    else if (cmd.oam_wr && in_address < 13'(tspr_pkg::SPRITE_BYTES))
      oam[in_address[7:2]][{in_address[1:0], 3'd0} +: 8] <= in_data;
    oam_q <= oam[scan];
  end

  assign by = scy + line;
  assign bx = scx + col;

  always_comb begin
    if (tile_uns) bg_tile_addr = {1'b0, tile, 4'd0};
    else bg_tile_addr = {~tile[7], tile[7], tile[6:0], 4'd0};
  end

  always_comb begin
    unique case (cmd.rsel)
      tspr_pkg::RA_MAP:   raddr = AW'({2'b11, map_sel, by[7:3], bx[7:3]});
      tspr_pkg::RA_BG_LO: raddr = AW'(bg_tile_addr + {8'd0, by[2:0], 1'b0});
      tspr_pkg::RA_BG_HI: raddr = AW'(bg_tile_addr + {8'd0, by[2:0], 1'b1});
      default:            raddr = AW'({1'b0, sp_tile, sp_row, cmd.sp_hi});
    endcase
  end

  // Sprite match for the entry fetched last cycle.
  logic [8:0] ey, ex, dy, dx;
  always_comb begin
    ey = {1'b0, oam_q[7:0]};
    ex = {1'b0, oam_q[15:8]};
    dy = {1'b0, line} + 9'd16 - ey;
    dx = {1'b0, col} + 9'd8 - ex;
    hit = (ey <= {1'b0, line} + 9'd16) && (dy < 9'd8)
          && (ex <= {1'b0, col} + 9'd8) && (dx < 9'd8);
  end
  assign stat.scan_hit = hit;
  assign stat.scan_end = scan_q >= SW'(NS - 1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      line <= in_line;
      col <= in_column;
    end
    if (cmd.cap_tile) tile <= rdata;
    if (cmd.cap_lo) bg_lo <= rdata;
    if (cmd.cap_bg) bg_idx <= {rdata[3'd7 - bx[2:0]], bg_lo[3'd7 - bx[2:0]]};
    scan_q <= scan;
    if (cmd.scan_start) begin
      scan <= '0;
      found <= 1'b0;
    end else if (cmd.scan_step && scan != SW'(NS - 1)) begin
      scan <= scan + 1'b1;
    end
    if (cmd.scan_chk && hit && !found) begin
      found <= 1'b1;
      sp_tile <= oam_q[23:16];
      sp_attr <= oam_q[31:24];
      sp_row <= dy[2:0];
      sp_col <= dx[2:0];
    end
    if (cmd.cap_slo) sp_lo <= rdata;
  end

  // Low byte register now valid; high byte is on rdata when the output state is entered.
  logic [1:0] sp_idx, sp_shade, bg_shade;
  logic use_sp;
  always_comb begin
    sp_idx = {rdata[3'd7 - sp_col], sp_lo[3'd7 - sp_col]};
    sp_shade = tspr_pkg::pal_map(sp_attr[4] ? obp1 : obp0, sp_idx);
    bg_shade = tspr_pkg::pal_map(bgp, bg_idx);
    use_sp = found && (!sp_attr[7] || bg_idx == 2'd0);
  end

  logic [1:0] shade_q;
  logic fs_q, fin_d;
  always_ff @(posedge clk) begin
    fin_d <= cmd.finish;
    if (cmd.finish && !fin_d) begin
      shade_q <= use_sp ? sp_shade : bg_shade;
      fs_q <= use_sp;
    end
  end
  assign out_line = line;
  assign out_column = col;
  assign shade = (cmd.finish && !fin_d) ? (use_sp ? sp_shade : bg_shade) : shade_q;
  assign from_sprite = (cmd.finish && !fin_d) ? use_sp : fs_q;
endmodule

// ----- dv/tb_top.sv -----
module tb_top;
  import tspr_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tspr_in_if in_ch();
  tspr_out_if out_ch();

  tile_sprite_pixel_renderer dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct packed {
    logic [7:0] line;
    logic [7:0] column;
    logic [1:0] shade;
    logic       from_sprite;
  } pixel_t;

  // Shadow of the renderer: memories, registers and the queue of expected pixels.
  class pixel_scoreboard;
    logic [7:0] vram [0:8191];
    logic [7:0] oam [0:159];
    logic map_high, tile_uns;
    logic [7:0] scy, scx, bgp, obp0, obp1;
    pixel_t pending[$];
    int errors;

    function new();
      foreach (vram[i]) vram[i] = 8'd0;
      foreach (oam[i]) oam[i] = 8'd0;
      map_high = 1'b0; tile_uns = 1'b1;
      scy = 8'd0; scx = 8'd0; bgp = 8'd252; obp0 = 8'd255; obp1 = 8'd255;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] v);
      case (idx)
        REG_MAP_SEL:  map_high = v[0];
        REG_TILE_UNS: tile_uns = v[0];
        REG_SCY:      scy = v;
        REG_SCX:      scx = v;
        REG_BGP:      bgp = v;
        REG_OBP0:     obp0 = v;
        REG_OBP1:     obp1 = v;
        default: ;
      endcase
    endfunction

    function logic [1:0] tile_index(logic [12:0] base, logic [2:0] row, logic [2:0] col);
      logic [7:0] lo, hi;
      lo = vram[base + {row, 1'b0}];
      hi = vram[base + {row, 1'b1}];
      return {hi[7 - col], lo[7 - col]};
    endfunction

    function logic [1:0] lookup(logic [7:0] pal, logic [1:0] idx);
      return pal[idx * 2 +: 2];
    endfunction

    function void note_item(action_t act, logic [12:0] addr, logic [7:0] data,
                            logic [7:0] line, logic [7:0] col);
      logic [7:0] by, bx, tile, pal;
      logic [12:0] taddr;
      logic [1:0] bg_idx, sp_idx;
      pixel_t px;
      int sy, sx;
      if (act == ACT_VRAM) begin
        vram[addr] = data;
        return;
      end
      if (act == ACT_OAM) begin
        if (addr < 13'd160) oam[addr] = data;
        return;
      end
      if (act != ACT_DRAW) return;
      by = scy + line;
      bx = scx + col;
      tile = vram[(map_high ? 13'h1C00 : 13'h1800) + {by[7:3], bx[7:3]}];
      // Signed area: index sign-extended around offset 0x1000.
      if (tile_uns) taddr = {1'b0, tile, 4'd0};
      else taddr = 13'h1000 + 13'({{5{tile[7]}}, tile} << 4);
      bg_idx = tile_index(taddr, by[2:0], bx[2:0]);
      px.line = line; px.column = col;
      px.shade = lookup(bgp, bg_idx);
      px.from_sprite = 1'b0;
      for (int i = 0; i < 40; i++) begin
        sy = int'(oam[4*i]) - 16;
        sx = int'(oam[4*i+1]) - 8;
        if (int'(line) >= sy && int'(line) < sy + 8 && int'(col) >= sx && int'(col) < sx + 8) begin
          sp_idx = tile_index({1'b0, oam[4*i+2], 4'd0}, 3'(int'(line) - sy),
                              3'(int'(col) - sx));
          pal = oam[4*i+3][4] ? obp1 : obp0;
          if (!oam[4*i+3][7] || bg_idx == 2'd0) begin
            px.shade = lookup(pal, sp_idx);
            px.from_sprite = 1'b1;
          end
          break;
        end
      end
      pending.push_back(px);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pixel %0d,%0d", got.line, got.column);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("pixel mismatch: want line %0d col %0d shade %0d spr %0b, got %0d %0d %0d %0b",
                   want.line, want.column, want.shade, want.from_sprite,
                   got.line, got.column, got.shade, got.from_sprite);
      end
    endfunction
  endclass

  pixel_scoreboard sb;
  bit quiet = 0;
  bit hold_off = 0;
  int cycles = 0;

  initial begin
    in_ch.valid = 1'b0; in_ch.action = ACT_NONE; in_ch.mem_address = '0;
    in_ch.mem_data = '0; in_ch.screen_line = '0; in_ch.screen_column = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("tb_top failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_pixel({out_ch.out_line, out_ch.out_column, out_ch.shade, out_ch.from_sprite});

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ch.ready = 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        n = $urandom_range(1, 13);
        repeat (n) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic send(action_t act, logic [12:0] addr, logic [7:0] data,
                      logic [7:0] line, logic [7:0] col);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      n = $urandom_range(1, 13);
      repeat (n) @(negedge clk);
    end
    in_ch.valid = 1'b1; in_ch.action = act; in_ch.mem_address = addr;
    in_ch.mem_data = data; in_ch.screen_line = line; in_ch.screen_column = col;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(act, addr, data, line, col);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic reg_write(logic [2:0] idx, logic [7:0] v);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = {idx, 2'b00}; pwdata = {24'd0, v};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic random_regs(bit extreme);
    for (int r = 0; r <= 6; r++)
      reg_write(3'(r), extreme ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom));
  endtask

  // Mostly render requests; writes aim mostly at the maps, tile data and sprites so renders hit content.
  task automatic random_item();
    int k;
    logic [12:0] a;
    k = $urandom_range(0, 99);
    if (k < 25) begin
      case ($urandom_range(0, 3))
        0: a = 13'h1800 + 13'($urandom_range(0, 2047));
        1: a = 13'($urandom_range(0, 511));
        2: a = 13'h0800 + 13'($urandom_range(0, 2047));
        default: a = 13'($urandom);
      endcase
      send(ACT_VRAM, a, 8'($urandom), 8'($urandom), 8'($urandom));
    end else if (k < 40) begin
      a = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 159));
      send(ACT_OAM, a, (a[1:0] == 2'd0) ? 8'($urandom_range(10, 170)) :
                       (a[1:0] == 2'd1) ? 8'($urandom_range(0, 175)) : 8'($urandom),
           8'($urandom), 8'($urandom));
    end else if (k < 42) begin
      send(ACT_NONE, 13'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      if ($urandom_range(0, 9) == 0)
        send(ACT_DRAW, 13'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      else
        send(ACT_DRAW, 13'($urandom), 8'($urandom), 8'($urandom_range(0, 143)),
             8'($urandom_range(0, 159)));
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(negedge clk);
    rst = 1'b0;
    // Directed: default render, memory extremes, sprite edge cases.
    send(ACT_DRAW, 13'd0, 8'd0, 8'd0, 8'd0);
    send(ACT_VRAM, 13'h1FFF, 8'hFF, 8'd0, 8'd0);
    send(ACT_VRAM, 13'h1800, 8'h01, 8'd0, 8'd0);
    send(ACT_VRAM, 13'h0010, 8'hAA, 8'd0, 8'd0);
    send(ACT_VRAM, 13'h0011, 8'h55, 8'd0, 8'd0);
    send(ACT_VRAM, 13'h0800, 8'hF0, 8'd0, 8'd0);
    send(ACT_DRAW, 13'd0, 8'd0, 8'd0, 8'd3);
    send(ACT_OAM, 13'd0, 8'd16, 8'd0, 8'd0);
    send(ACT_OAM, 13'd1, 8'd8, 8'd0, 8'd0);
    send(ACT_OAM, 13'd2, 8'd1, 8'd0, 8'd0);
    send(ACT_OAM, 13'd3, 8'h90, 8'd0, 8'd0);
    send(ACT_OAM, 13'd160, 8'hFF, 8'd0, 8'd0);
    send(ACT_OAM, 13'h1FFF, 8'hFF, 8'd0, 8'd0);
    send(ACT_OAM, 13'd159, 8'hFF, 8'd0, 8'd0);
    send(ACT_DRAW, 13'd0, 8'd0, 8'd0, 8'd1);
    send(ACT_DRAW, 13'd0, 8'd0, 8'd7, 8'd7);
    send(ACT_NONE, 13'h1FFF, 8'hFF, 8'hFF, 8'hFF);
    send(ACT_DRAW, 13'h1FFF, 8'hFF, 8'hFF, 8'hFF);
    send(ACT_DRAW, 13'd0, 8'd0, 8'd143, 8'd159);
    drain();
    reg_write(REG_TILE_UNS, 8'd0);
    reg_write(REG_MAP_SEL, 8'd1);
    reg_write(REG_SCY, 8'hFF);
    reg_write(REG_SCX, 8'hFF);
    reg_write(REG_BGP, 8'h1B);
    reg_write(REG_OBP0, 8'h00);
    reg_write(REG_OBP1, 8'hE4);
    send(ACT_VRAM, 13'h1C00, 8'h80, 8'd0, 8'd0);
    send(ACT_DRAW, 13'd0, 8'd0, 8'd1, 8'd1);
    send(ACT_DRAW, 13'd0, 8'd0, 8'd0, 8'd0);
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      random_regs(phase == 1 || phase == 4);
      for (int i = 0; i < 160; i++) begin
        if (phase == 2 && i == 20) hold_off = 1;
        random_item();
      end
      drain();
    end
    quiet = 1;
    for (int i = 0; i < 100; i++) random_item();
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/tspr_pkg.sv
rtl/core/tspr_if.sv
rtl/core/tspr_ctrl.sv
rtl/core/tspr_datapath.sv
rtl/core/tile_sprite_pixel_renderer.sv
dv/tb_top.sv
